[hw/rtl/rml_pkg.sv]
// rml_pkg: types and constants shared by the recent-items list blocks
// no dependencies; imported by rml_cell, rml_chain and recent_items_mru_list_top
`default_nettype none

package rml_pkg;

    // operation codes carried on the slave tuser
    localparam int OP_W = 2;
    typedef enum logic [OP_W-1:0] {
        OP_USE  = 2'd0,
        OP_DEL  = 2'd1,
        OP_READ = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    // configuration register indexes
    localparam int CFG_ADDR_W = 1;
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CAPACITY = 1'b0,
        CFG_FREEZE   = 1'b1
    } t_cfg_reg;

    localparam int          CAP_W     = 6;
    localparam logic [CAP_W-1:0] CAP_RESET = 6'd20;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic use_op;   // effective use beat (id nonzero, not frozen)
        logic del_op;   // delete beat
        logic evict;    // list at capacity, an insert drops the oldest
    } t_cell_cmd;

endpackage

`default_nettype wire

[hw/rtl/recent_items_mru_list_top.sv]
// recent_items_mru_list_top: bounded most-recently-used id list, newest first
// depends on rml_pkg and rml_chain (which holds the rml_cell row)
//
// channel   dir  handshake             contents
// s_axis    in   tvalid/tready         tuser: opcode; tdata: item_id, position
// m_axis    out  tvalid/tready         tdata: hit .. read_id (see port)
// cfg       in   i_cfg_we, no wait     i_cfg_addr 0 capacity, 1 freeze_mode
//
// one beat per cycle while s_axis_tready is high: each cell compares its slot and shifts in the same cycle
// the critical path is the id compare plus the match prefix chain across all cells
// the result lands in an output register in the cycle after the input beat
// s_axis_tready drops only while a result waits and m_axis_tready is low
// synchronous active-low reset empties the list and restores the register defaults
`default_nettype none

module recent_items_mru_list_top
    import rml_pkg::*;
#(
    parameter int MAX_ENTRIES = 32,
    parameter int ID_BITS     = 15,
    localparam int CNT_W      = $clog2(MAX_ENTRIES + 1),
    localparam int POS_W      = $clog2(MAX_ENTRIES),
    localparam int IN_W       = ((ID_BITS + POS_W + 7) / 8) * 8,
    localparam int OUT_USED   = 3 + 2 * ID_BITS + CNT_W,
    localparam int OUT_W      = ((OUT_USED + 7) / 8) * 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // slave side
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_W-1:0]       s_axis_tdata,  // item_id, position, zero fill
    input  wire logic [OP_W-1:0]       s_axis_tuser,  // opcode
    // master side
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // hit, evicted_valid, evicted_id, entry_count, read_valid, read_id, zero fill
    output logic [OUT_W-1:0]           m_axis_tdata,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CAP_W-1:0]      i_cfg_wdata
);

    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0]   r_capacity;
    logic               r_freeze;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    logic               r_valid;
    logic               r_hit;
    logic               r_ev_valid;
    logic [ID_BITS-1:0] r_ev_id;
    logic [CNT_W-1:0]   r_cnt_out;
    logic               r_rd_valid;
    logic [ID_BITS-1:0] r_rd_id;

    logic               w_in_beat;
    logic [OP_W-1:0]    w_op;
    logic [ID_BITS-1:0] w_id;
    logic [POS_W-1:0]   w_pos;
    logic [CAP_W-1:0]   w_cap_eff;
    t_cell_cmd          w_cmd;
    logic               w_hit_any;
    logic [MAX_ENTRIES-1:0] w_matches;
    logic [ID_BITS-1:0] w_rd_id;
    logic [ID_BITS-1:0] w_ev_id;
    logic               w_rd_ok;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;
    assign w_op          = s_axis_tuser;
    assign w_id          = s_axis_tdata[ID_BITS-1:0];
    assign w_pos         = s_axis_tdata[ID_BITS +: POS_W];

    // capacity zero acts as one, above the slot count acts as the slot count
    assign w_cap_eff = (r_capacity == '0) ? CAP_W'(1) : r_capacity;

    assign w_cmd.use_op = w_in_beat && (w_op == OP_USE) && (w_id != '0) && !r_freeze;
    assign w_cmd.del_op = w_in_beat && (w_op == OP_DEL);
    assign w_cmd.evict  = (CMP_W'(r_count) >= CMP_W'(w_cap_eff)) ||
                          (r_count == CNT_W'(MAX_ENTRIES));

    rml_chain #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ID_BITS     (ID_BITS),
        .CNT_W       (CNT_W),
        .POS_W       (POS_W)
    ) u_chain (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_count   (r_count),
        .i_id      (w_id),
        .i_pos     (w_pos),
        .o_hit_any (w_hit_any),
        .o_matches (w_matches),
        .o_rd_id   (w_rd_id),
        .o_ev_id   (w_ev_id)
    );

    assign w_rd_ok = (w_op == OP_READ) && (CNT_W'(w_pos) < r_count);

    always_comb begin
        n_count = r_count;
        if (w_cmd.use_op && !w_hit_any && !w_cmd.evict) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_cmd.del_op && w_hit_any) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
            r_freeze   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CAPACITY: r_capacity <= i_cfg_wdata;
                CFG_FREEZE:   r_freeze   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_in_beat) begin
                r_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_hit      <= (w_cmd.use_op || w_cmd.del_op) && w_hit_any;
            r_ev_valid <= w_cmd.use_op && !w_hit_any && w_cmd.evict;
            r_ev_id    <= (w_cmd.use_op && !w_hit_any && w_cmd.evict) ? w_ev_id : '0;
            r_cnt_out  <= n_count;
            r_rd_valid <= w_rd_ok;
            r_rd_id    <= w_rd_ok ? w_rd_id : '0;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {{(OUT_W - OUT_USED){1'b0}},
                            r_rd_id, r_rd_valid, r_cnt_out, r_ev_id, r_ev_valid, r_hit};

    // the list never holds more ids than slots
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above slot count");

    // ids in the valid slots stay distinct
    a_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_matches))
        else $error("id matched in more than one slot");

    // a delete that hits shrinks the list by one
    a_del_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.del_op && w_hit_any |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("delete hit did not shrink the list");

    // a hit never reports an eviction
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_hit |-> !r_ev_valid)
        else $error("eviction reported on a hit");

endmodule

`default_nettype wire

[hw/rtl/rml_cell.sv]
// rml_cell: one list slot, holds an id and moves it toward either neighbor
// depends on rml_pkg (t_cell_cmd)
`default_nettype none

module rml_cell
    import rml_pkg::*;
#(
    parameter int IDX     = 0,
    parameter int ID_BITS = 15,
    parameter int CNT_W   = 6
) (
    input  wire logic               i_clk,
    input  wire t_cell_cmd          i_cmd,
    input  wire logic               i_hit_any,
    input  wire logic               i_match_left,
    input  wire logic [CNT_W-1:0]   i_count,
    input  wire logic [ID_BITS-1:0] i_id,
    input  wire logic [ID_BITS-1:0] i_left,
    input  wire logic [ID_BITS-1:0] i_right,
    output logic [ID_BITS-1:0]      o_entry,
    output logic                    o_match
);

    logic [ID_BITS-1:0] r_entry;
    logic [ID_BITS-1:0] n_entry;
    logic               w_valid;
    logic               w_at_count;
    logic               w_has_right;
    logic               w_take_left;
    logic               w_take_right;

    assign w_valid     = CNT_W'(IDX) < i_count;
    assign w_at_count  = CNT_W'(IDX) == i_count;
    assign w_has_right = CNT_W'(IDX + 1) < i_count;
    assign o_match     = w_valid && (r_entry == i_id);

    // hit: slots up to the match shift back; miss: slots up to the fill limit shift back
    assign w_take_left = i_cmd.use_op &&
                         (i_hit_any ? !i_match_left
                                    : (w_valid || (!i_cmd.evict && w_at_count)));
    // delete closes the gap from the match onward
    assign w_take_right = i_cmd.del_op && (i_match_left || o_match) && w_has_right;

    always_comb begin
        n_entry = r_entry;
        if (w_take_left) begin
            n_entry = i_left;
        end else if (w_take_right) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

[hw/rtl/rml_chain.sv]
// rml_chain: row of rml_cell slots with the match prefix chain and slot selects
// depends on rml_pkg and rml_cell
`default_nettype none

module rml_chain
    import rml_pkg::*;
#(
    parameter int MAX_ENTRIES = 32,
    parameter int ID_BITS     = 15,
    parameter int CNT_W       = 6,
    parameter int POS_W       = 5
) (
    input  wire logic               i_clk,
    input  wire t_cell_cmd          i_cmd,
    input  wire logic [CNT_W-1:0]   i_count,
    input  wire logic [ID_BITS-1:0] i_id,
    input  wire logic [POS_W-1:0]   i_pos,
    output logic                    o_hit_any,
    output logic [MAX_ENTRIES-1:0]  o_matches,
    output logic [ID_BITS-1:0]      o_rd_id,
    output logic [ID_BITS-1:0]      o_ev_id
);

    logic [ID_BITS-1:0] w_entry [MAX_ENTRIES];
    logic [MAX_ENTRIES:0] w_match_left;

    assign w_match_left[0] = 1'b0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic [ID_BITS-1:0] w_left;
        logic [ID_BITS-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = i_id;
        end else begin : g_body
            assign w_left = w_entry[g-1];
        end

        if (g == MAX_ENTRIES - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        rml_cell #(
            .IDX     (g),
            .ID_BITS (ID_BITS),
            .CNT_W   (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (i_cmd),
            .i_hit_any    (o_hit_any),
            .i_match_left (w_match_left[g]),
            .i_count      (i_count),
            .i_id         (i_id),
            .i_left       (w_left),
            .i_right      (w_right),
            .o_entry      (w_entry[g]),
            .o_match      (o_matches[g])
        );

        assign w_match_left[g+1] = w_match_left[g] | o_matches[g];
    end

    assign o_hit_any = w_match_left[MAX_ENTRIES];

    // slot selects for the read position and the oldest valid slot
    always_comb begin
        o_rd_id = '0;
        o_ev_id = '0;
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            if (POS_W'(k) == i_pos) begin
                o_rd_id = w_entry[k];
            end
            if (CNT_W'(k + 1) == i_count) begin
                o_ev_id = w_entry[k];
            end
        end
    end

endmodule

`default_nettype wire
